>>> rtl/core/hpr_pkg.sv
// Shared package for the hue palette recolor unit.
// Command codes, the 5-to-8-bit expansion table, the color widening and the
// controller-to-datapath command struct. No dependencies.
`timescale 1ns / 1ps
package hpr_pkg;

  localparam int MAX_HUES      = 4096;
  localparam int SLOTS_PER_HUE = 32;
  localparam int SLOT_W        = 5;
  localparam int CNT_W         = 13;

  localparam logic [2:0] CMD_WRITE   = 3'd0;
  localparam logic [2:0] CMD_RECOL16 = 3'd1;
  localparam logic [2:0] CMD_RECOL32 = 3'd2;
  localparam logic [2:0] CMD_PARTIAL = 3'd3;
  localparam logic [2:0] CMD_FONT    = 3'd4;
  localparam logic [2:0] CMD_POLY    = 3'd5;

  localparam logic [SLOT_W-1:0] FONT_SLOT    = 5'd8;
  localparam logic [31:0]       POLY_DEFAULT = 32'hFF01_0101;

  typedef struct packed {
    logic capture;
    logic access;
    logic form;
  } ctrl_cmd_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0] r;
    case (v)
      5'd0:  r = 8'h00;  5'd1:  r = 8'h08;  5'd2:  r = 8'h10;  5'd3:  r = 8'h18;
      5'd4:  r = 8'h20;  5'd5:  r = 8'h29;  5'd6:  r = 8'h31;  5'd7:  r = 8'h39;
      5'd8:  r = 8'h41;  5'd9:  r = 8'h4A;  5'd10: r = 8'h52;  5'd11: r = 8'h5A;
      5'd12: r = 8'h62;  5'd13: r = 8'h6A;  5'd14: r = 8'h73;  5'd15: r = 8'h7B;
      5'd16: r = 8'h83;  5'd17: r = 8'h8B;  5'd18: r = 8'h94;  5'd19: r = 8'h9C;
      5'd20: r = 8'hA4;  5'd21: r = 8'hAC;  5'd22: r = 8'hB4;  5'd23: r = 8'hBD;
      5'd24: r = 8'hC5;  5'd25: r = 8'hCD;  5'd26: r = 8'hD5;  5'd27: r = 8'hDE;
      5'd28: r = 8'hE6;  5'd29: r = 8'hEE;  5'd30: r = 8'hF6;  default: r = 8'hFF;
    endcase
    return r;
  endfunction

  // red in byte 0, green in byte 1, blue in byte 2
  function automatic logic [31:0] widen(input logic [15:0] c);
    return {8'h00, expand5(c[4:0]), expand5(c[9:5]), expand5(c[14:10])};
  endfunction

endpackage

>>> rtl/core/hpr_ctrl.sv
// Controller for the hue palette recolor unit: capture, table access, form.
// Depends on hpr_pkg.
`timescale 1ns / 1ps
module hpr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  output hpr_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MEM  = 2'd1;
  localparam logic [1:0] ST_FORM = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;
  logic       accept;

  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_MEM;
      end
      ST_MEM:  state_d = ST_FORM;
      ST_FORM: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign done_d = (state_q == ST_FORM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign done_o        = done_q;
  assign cmd_o.capture = accept;
  assign cmd_o.access  = (state_q == ST_MEM);
  assign cmd_o.form    = (state_q == ST_FORM);

  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("result strobe missing three cycles after accept");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("not busy after accepted transfer");

endmodule

>>> rtl/core/hpr_dpath.sv
// Datapath for the hue palette recolor unit: count register, hue table memory,
// address and hit logic, color expansion and result registers. Depends on hpr_pkg.
`timescale 1ns / 1ps
module hpr_dpath #(
  parameter int MaxHues = hpr_pkg::MAX_HUES
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [hpr_pkg::CNT_W-1:0]  cfg_data_i,
  input  hpr_pkg::ctrl_cmd_t         cmd_i,
  input  logic [2:0]                 command_i,
  input  logic [15:0]                pixel_i,
  input  logic [15:0]                hue_i,
  input  logic [4:0]                 slot_i,
  input  logic [15:0]                word_i,
  output logic [15:0]                color16_o,
  output logic [31:0]                color32_o,
  output logic                       hued_o
);

  localparam int EntryW = (MaxHues > 1) ? $clog2(MaxHues) : 1;
  localparam int AddrW  = EntryW + hpr_pkg::SLOT_W;
  localparam int Depth  = MaxHues * hpr_pkg::SLOTS_PER_HUE;
  localparam logic [16:0] MaxHuesV = 17'(MaxHues);

  logic [hpr_pkg::CNT_W-1:0] hue_count_q;
  logic [16:0]               eff_cnt, cnt_ext;
  logic                      in_range, apply, gray, flag;
  logic [15:0]               entry;
  logic [4:0]                slot_sel;

  logic [2:0]       cmd_q;
  logic [15:0]      pix_q, word_q;
  logic             flag_q;
  logic [AddrW-1:0] addr_q;
  logic [15:0]      rdata_q;
  logic [15:0]      mem [Depth];

  logic [15:0] c16_d, c16_q;
  logic [31:0] c32_d, c32_q;
  logic        hued_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_count_q <= '0;
    end else if (cfg_we_i) begin
      hue_count_q <= cfg_data_i;
    end
  end

  assign cnt_ext  = 17'(hue_count_q);
  assign eff_cnt  = (cnt_ext < MaxHuesV) ? cnt_ext : MaxHuesV;
  assign in_range = ({1'b0, hue_i} < eff_cnt);
  assign apply    = in_range && (hue_i != 16'd0);
  assign gray     = (pixel_i[14:10] == pixel_i[9:5]) && (pixel_i[14:10] == pixel_i[4:0]);
  assign entry    = (command_i == hpr_pkg::CMD_WRITE) ? hue_i : hue_i - 16'd1;

  always_comb begin
    slot_sel = pixel_i[14:10];
    flag     = apply;
    case (command_i)
      hpr_pkg::CMD_WRITE: begin
        slot_sel = slot_i;
        flag     = in_range;
      end
      hpr_pkg::CMD_PARTIAL: flag = apply && gray;
      hpr_pkg::CMD_FONT:    slot_sel = hpr_pkg::FONT_SLOT;
      hpr_pkg::CMD_POLY:    slot_sel = pixel_i[4:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= command_i;
      pix_q  <= pixel_i;
      word_q <= word_i;
      flag_q <= flag;
      addr_q <= {entry[EntryW-1:0], slot_sel};
    end
  end

  // table port: one registered read per item, plus one write for an in-range write command
  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      if (cmd_q == hpr_pkg::CMD_WRITE && flag_q) begin
        mem[addr_q] <= word_q;
      end
      rdata_q <= mem[addr_q];
    end
  end

  always_comb begin
    c16_d = 16'd0;
    c32_d = 32'd0;
    case (cmd_q)
      hpr_pkg::CMD_RECOL16: c16_d = flag_q ? rdata_q : pix_q;
      hpr_pkg::CMD_RECOL32, hpr_pkg::CMD_PARTIAL, hpr_pkg::CMD_FONT:
        c32_d = hpr_pkg::widen(flag_q ? rdata_q : pix_q);
      hpr_pkg::CMD_POLY:
        c32_d = flag_q ? hpr_pkg::widen(rdata_q) : hpr_pkg::POLY_DEFAULT;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.form) begin
      c16_q  <= c16_d;
      c32_q  <= c32_d;
      hued_q <= flag_q && (cmd_q <= hpr_pkg::CMD_POLY);
    end
  end

  assign color16_o = c16_q;
  assign color32_o = c32_q;
  assign hued_o    = hued_q;

endmodule

>>> rtl/core/hue_palette_recolor_unit.sv
// Top level of the hue palette recolor unit: hue table writes and recolor lookups.
// Depends on hpr_pkg, hpr_ctrl and hpr_dpath.
//
//  channel  | signals                                   | flow
//  ---------+-------------------------------------------+-----------------------
//  command  | start, busy, command/pixel/hue/slot/word  | transfer: start & !busy
//  result   | done_o, color16_o, color32_o, hued_o      | one-cycle strobe
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i      | transfer: valid & ready
//
// Each item passes through capture, one table access (single-port memory,
// registered read) and result forming. The result strobe follows the forming
// state, and a new command can be taken in the same cycle as the strobe.
// The receiver cannot stall; config is always ready. Reset clears the hue count
// and control state; the table holds nothing defined until written.
`timescale 1ns / 1ps
module hue_palette_recolor_unit #(
  parameter int MaxHues = hpr_pkg::MAX_HUES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                command_i,
  input  logic [15:0]               pixel_i,
  input  logic [15:0]               hue_i,
  input  logic [4:0]                slot_i,
  input  logic [15:0]               word_i,
  output logic                      done_o,
  output logic [15:0]               color16_o,
  output logic [31:0]               color32_o,
  output logic                      hued_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hpr_pkg::CNT_W-1:0] cfg_data_i
);

  hpr_pkg::ctrl_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  hpr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  hpr_dpath #(
    .MaxHues (MaxHues)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .command_i  (command_i),
    .pixel_i    (pixel_i),
    .hue_i      (hue_i),
    .slot_i     (slot_i),
    .word_i     (word_i),
    .color16_o  (color16_o),
    .color32_o  (color32_o),
    .hued_o     (hued_o)
  );

endmodule

>>> tb/sv/testbench.sv
// Testbench for hue_palette_recolor_unit: table writes and recolor lookups are
// driven, results are predicted in order and compared field by field.
// Depends on hpr_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module testbench;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 150;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] pixel;
    logic [15:0] hue;
    logic [4:0]  slot;
    logic [15:0] word;
  } hue_cmd_t;

  typedef struct packed {
    logic [15:0] color16;
    logic [31:0] color32;
    logic        hued;
  } recolor_t;

  typedef struct {
    hue_cmd_t cmd;
    recolor_t res;
  } recolor_job_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [2:0]        command_i;
  logic [15:0]       pixel_i;
  logic [15:0]       hue_i;
  logic [4:0]        slot_i;
  logic [15:0]       word_i;
  logic              done_o;
  logic [15:0]       color16_o;
  logic [31:0]       color32_o;
  logic              hued_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [hpr_pkg::CNT_W-1:0] cfg_data_i;

  recolor_job_t pending_jobs_q[$];
  recolor_t     recolor_expect_q[$];
  logic [15:0]  hue_words[int];
  int           full_entries[$];
  logic [hpr_pkg::CNT_W-1:0] hue_count_r;
  int           errors;
  int           sent_count;
  int           quiet_cycles;
  bit           took;

  const logic [7:0] gamma5[32] = '{
    8'h00, 8'h08, 8'h10, 8'h18, 8'h20, 8'h29, 8'h31, 8'h39,
    8'h41, 8'h4A, 8'h52, 8'h5A, 8'h62, 8'h6A, 8'h73, 8'h7B,
    8'h83, 8'h8B, 8'h94, 8'h9C, 8'hA4, 8'hAC, 8'hB4, 8'hBD,
    8'hC5, 8'hCD, 8'hD5, 8'hDE, 8'hE6, 8'hEE, 8'hF6, 8'hFF};

  hue_palette_recolor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .command_i   (command_i),
    .pixel_i     (pixel_i),
    .hue_i       (hue_i),
    .slot_i      (slot_i),
    .word_i      (word_i),
    .done_o      (done_o),
    .color16_o   (color16_o),
    .color32_o   (color32_o),
    .hued_o      (hued_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int eff_hues();
    return (int'(hue_count_r) < hpr_pkg::MAX_HUES) ? int'(hue_count_r) : hpr_pkg::MAX_HUES;
  endfunction

  function automatic logic [31:0] to_rgb32(input logic [15:0] c);
    return {8'h00, gamma5[c[4:0]], gamma5[c[9:5]], gamma5[c[14:10]]};
  endfunction

  function automatic logic [4:0] lookup_slot(input hue_cmd_t c);
    if (c.command == hpr_pkg::CMD_FONT) return hpr_pkg::FONT_SLOT;
    if (c.command == hpr_pkg::CMD_POLY) return c.pixel[4:0];
    return c.pixel[14:10];
  endfunction

  function automatic int lookup_addr(input hue_cmd_t c);
    return (int'(c.hue) - 1) * hpr_pkg::SLOTS_PER_HUE + int'(lookup_slot(c));
  endfunction

  function automatic bit uses_table(input hue_cmd_t c);
    bit hit;
    bit gray;
    hit = c.hue != 0 && int'(c.hue) < eff_hues();
    gray = c.pixel[14:10] == c.pixel[9:5] && c.pixel[14:10] == c.pixel[4:0];
    case (c.command)
      hpr_pkg::CMD_RECOL16, hpr_pkg::CMD_RECOL32, hpr_pkg::CMD_FONT,
      hpr_pkg::CMD_POLY: return hit;
      hpr_pkg::CMD_PARTIAL: return hit && gray;
      default: return 1'b0;
    endcase
  endfunction

  function automatic recolor_t predict_recolor(input hue_cmd_t c);
    recolor_t r;
    logic [15:0] src;
    bit hit;
    r = '0;
    hit = uses_table(c);
    src = hit ? hue_words[lookup_addr(c)] : c.pixel;
    case (c.command)
      hpr_pkg::CMD_WRITE: begin
        if (int'(c.hue) < eff_hues()) begin
          hue_words[int'(c.hue) * hpr_pkg::SLOTS_PER_HUE + int'(c.slot)] = c.word;
          r.hued = 1'b1;
        end
      end
      hpr_pkg::CMD_RECOL16: r.color16 = src;
      hpr_pkg::CMD_RECOL32, hpr_pkg::CMD_PARTIAL, hpr_pkg::CMD_FONT:
        r.color32 = to_rgb32(src);
      hpr_pkg::CMD_POLY: r.color32 = hit ? to_rgb32(src) : hpr_pkg::POLY_DEFAULT;
      default: ;
    endcase
    if (hit) r.hued = 1'b1;
    return r;
  endfunction

  task automatic add_cmd(input logic [2:0] command, input logic [15:0] pixel,
                         input logic [15:0] hue, input logic [4:0] slot,
                         input logic [15:0] word);
    recolor_job_t job;
    job.cmd = '{command: command, pixel: pixel, hue: hue, slot: slot, word: word};
    // never read a table word that was not written
    if (uses_table(job.cmd) && !hue_words.exists(lookup_addr(job.cmd)))
      job.cmd.hue = '0;
    job.res = predict_recolor(job.cmd);
    pending_jobs_q.push_back(job);
  endtask

  task automatic fill_entry(input int e);
    if (e < 0 || e >= eff_hues()) return;
    foreach (full_entries[i]) if (full_entries[i] == e) return;
    for (int s = 0; s < hpr_pkg::SLOTS_PER_HUE; s++)
      add_cmd(hpr_pkg::CMD_WRITE, 16'($urandom), 16'(e), 5'(s), 16'($urandom));
    full_entries.push_back(e);
  endtask

  task automatic add_random_cmd();
    int roll;
    int lim;
    int live[$];
    logic [15:0] hue;
    logic [15:0] pixel;
    logic [2:0] command;
    logic [4:0] v;
    roll = $urandom_range(99);
    lim = eff_hues();
    pixel = 16'($urandom);
    if (roll < 25) begin
      case ($urandom_range(4))
        0, 1, 2: hue = (lim > 0) ? 16'($urandom_range(lim - 1)) : 16'h0;
        3: hue = 16'(lim - 1 + $urandom_range(2));
        default: hue = 16'($urandom);
      endcase
      add_cmd(hpr_pkg::CMD_WRITE, pixel, hue, 5'($urandom), 16'($urandom));
    end else if (roll < 85) begin
      foreach (full_entries[i]) if (full_entries[i] + 1 < lim) live.push_back(full_entries[i]);
      command = 3'($urandom_range(int'(hpr_pkg::CMD_RECOL16), int'(hpr_pkg::CMD_POLY)));
      hue = (live.size() > 0) ? 16'(live[$urandom_range(live.size() - 1)] + 1)
                              : 16'($urandom);
      if ($urandom_range(1)) begin
        v = 5'($urandom);
        pixel = {1'($urandom), v, v, v};
      end
      add_cmd(command, pixel, hue, 5'($urandom), 16'($urandom));
    end else if (roll < 97) begin
      command = 3'($urandom_range(int'(hpr_pkg::CMD_RECOL16), int'(hpr_pkg::CMD_POLY)));
      case ($urandom_range(4))
        0: hue = 16'h0;
        1: hue = 16'(lim);
        2: hue = 16'(lim + 1);
        3: hue = 16'hFFFF;
        default: hue = 16'($urandom);
      endcase
      add_cmd(command, pixel, hue, 5'($urandom), 16'($urandom));
    end else begin
      command = $urandom_range(1) ? CMD_SPARE7 : CMD_SPARE6;
      add_cmd(command, pixel, 16'($urandom), 5'($urandom), 16'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_jobs_q.size() > 0 || recolor_expect_q.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic write_hue_count(input logic [hpr_pkg::CNT_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    hue_count_r = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_directed();
    add_cmd(hpr_pkg::CMD_WRITE,   16'h0000, 16'd4095, 5'd31, 16'hFFFF);
    add_cmd(hpr_pkg::CMD_WRITE,   16'hFFFF, 16'd4096, 5'd0,  16'h1234);
    add_cmd(hpr_pkg::CMD_WRITE,   16'h0000, 16'hFFFF, 5'd31, 16'h8000);
    add_cmd(hpr_pkg::CMD_RECOL16, 16'hFFFF, 16'd1,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_RECOL16, 16'h0000, 16'd4095, 5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_RECOL16, 16'hFFFF, 16'd0,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_RECOL32, 16'h7C00, 16'd1,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_RECOL32, 16'hFFFF, 16'd0,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_RECOL32, 16'h03E0, 16'd4096, 5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_PARTIAL, 16'h7FFF, 16'd1,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_PARTIAL, 16'h0000, 16'd4095, 5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_PARTIAL, 16'h7C00, 16'd1,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_FONT,    16'h1234, 16'd1,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_FONT,    16'h7FFF, 16'd0,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_POLY,    16'h001F, 16'd1,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_POLY,    16'h8000, 16'd4095, 5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_POLY,    16'h7FFF, 16'd0,    5'd0,  16'h0000);
    add_cmd(hpr_pkg::CMD_POLY,    16'h0001, 16'd4096, 5'd0,  16'h0000);
    add_cmd(CMD_SPARE6,           16'hFFFF, 16'hFFFF, 5'd31, 16'hFFFF);
    add_cmd(CMD_SPARE7,           16'hFFFF, 16'd1,    5'd31, 16'hFFFF);
  endtask

  // command driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && !took)) begin
      if (pending_jobs_q.size() > 0 &&
          ((sent_count >= 300 && sent_count < 500) || $urandom_range(99) >= 25)) begin
        start     <= 1'b1;
        command_i <= pending_jobs_q[0].cmd.command;
        pixel_i   <= pending_jobs_q[0].cmd.pixel;
        hue_i     <= pending_jobs_q[0].cmd.hue;
        slot_i    <= pending_jobs_q[0].cmd.slot;
        word_i    <= pending_jobs_q[0].cmd.word;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // transfer tracking, result checking and watchdog
  always @(posedge clk_i) begin
    recolor_job_t job;
    recolor_t want;
    if (rst_ni) begin
      took = start && !busy;
      if (took) begin
        job = pending_jobs_q.pop_front();
        recolor_expect_q.push_back(job.res);
        sent_count++;
      end
      if (done_o) begin
        if (recolor_expect_q.size() == 0) begin
          $error("result with no transfer pending: color16 %h color32 %h hued %b",
                 color16_o, color32_o, hued_o);
          errors++;
        end else begin
          want = recolor_expect_q.pop_front();
          if (color16_o !== want.color16) begin
            $error("color16 expected %h got %h", want.color16, color16_o);
            errors++;
          end
          if (color32_o !== want.color32) begin
            $error("color32 expected %h got %h", want.color32, color32_o);
            errors++;
          end
          if (hued_o !== want.hued) begin
            $error("hued expected %b got %b", want.hued, hued_o);
            errors++;
          end
        end
      end
      if (took || done_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("hue_palette_recolor_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    logic [hpr_pkg::CNT_W-1:0] counts[6];
    counts = '{13'd0, 13'd2, 13'd4096, 13'd37, 13'h1FFF, 13'd1};
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = '0;
    pixel_i = '0;
    hue_i = '0;
    slot_i = '0;
    word_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    hue_count_r = '0;
    errors = 0;
    sent_count = 0;
    quiet_cycles = 0;
    took = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (counts[p]) begin
      write_hue_count(counts[p]);
      fill_entry(0);
      fill_entry(eff_hues() - 2);
      if (counts[p] == 13'd4096) add_directed();
      for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) add_random_cmd();
      wait_drained();
      for (int i = 0; i < RANDOM_PER_PHASE / 2; i++) add_random_cmd();
      wait_drained();
      repeat (3) @(posedge clk_i);
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("hue_palette_recolor_unit: match");
    end else begin
      $display("hue_palette_recolor_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/hpr_pkg.sv
rtl/core/hpr_ctrl.sv
rtl/core/hpr_dpath.sv
rtl/core/hue_palette_recolor_unit.sv
tb/sv/testbench.sv
